@@ src/assert_macros.svh @@
// Assertion macros shared by the even-sum table RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge while reset is released.
`define ESP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("concurrent assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ESP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("concurrent assertion failed");

`endif

@@ src/esput_pkg.sv @@
// Shared widths and types for the even-sum point update table.
// No dependencies; used by esput_sum and the top level of the block.
package esput_pkg;

	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned AMOUNT_W = 32;
	localparam int unsigned SUM_W    = 42;

	// Item codes for the action field.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_ADD  = 1'b1;

	// Sum update handed from the entry stage to the accumulator.
	typedef struct packed {
		logic             valid;
		logic             apply;
		logic [SUM_W-1:0] old_part;
		logic [SUM_W-1:0] new_part;
	} sum_upd_t;

endpackage

@@ src/esput_store.sv @@
// Entry memory of the even-sum table: one write port, one read port with a
// registered read. Depends on assert_macros.svh.
`include "assert_macros.svh"

module esput_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the contents before a write to the same entry in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

	`ESP_ASSERT(a_waddr_range, clk, arst_n, !we || (32'(waddr) < 32'(DEPTH)))

endmodule

@@ src/esput_sum.sv @@
// Running even-sum accumulator and result strobe of the even-sum table.
// Depends on esput_pkg for the update struct and the sum width.
module esput_sum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  esput_pkg::sum_upd_t             upd,
	output logic                            done,
	output logic [esput_pkg::SUM_W-1:0]     even_sum
);

	logic [esput_pkg::SUM_W-1:0] sum_q;
	logic                        done_q;

	// Take the old entry out of the sum and put the new one in, modulo 2^SUM_W.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= upd.valid;
			if (upd.valid && upd.apply) begin
				sum_q <= sum_q - upd.old_part + upd.new_part;
			end
		end
	end

	assign done     = done_q;
	assign even_sum = sum_q;

endmodule

@@ src/even_sum_point_update_table_unit.sv @@
// Top level of the even-sum point update table: entry stage, clearing sweep
// and wiring. Depends on esput_pkg, esput_store, esput_sum, assert_macros.svh.
`include "assert_macros.svh"

// After reset the table is swept to zero, one entry a cycle, over all
// TABLE_DEPTH entries; busy is high for that time and start is ignored.
// Afterwards busy stays low and one item may be transferred every clock
// cycle. Each item is a read-modify-write of one entry: the read is issued
// at the transfer edge, the next cycle computes and writes back the entry
// (a following item to the same entry takes the new value by forwarding),
// and the cycle after that updates the sum. The result strobe done rises
// together with the updated sum and lasts one cycle; the receiver cannot
// stall it, and results come out one per item, in order. An index at or
// beyond TABLE_DEPTH leaves the table and the sum unchanged but still
// returns the current sum.
module even_sum_point_update_table_unit #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   action,
	input  logic [esput_pkg::INDEX_W-1:0]          index,
	input  logic signed [esput_pkg::AMOUNT_W-1:0]  amount,
	output logic                                   done,
	output logic signed [esput_pkg::SUM_W-1:0]     even_sum
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned IW = esput_pkg::INDEX_W;
	localparam int unsigned CW = (AW > IW) ? AW : IW;
	localparam int unsigned EW = ENTRY_WIDTH;
	localparam int unsigned XW = 64;
	localparam int unsigned SW = esput_pkg::SUM_W;

	// Clearing sweep state.
	logic          clr_active_q;
	logic [AW-1:0] clr_cnt_q;

	// Entry stage registers.
	logic          vld_s1;
	logic          act_s1;
	logic          rng_s1;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] amt_s1;
	logic          fwd_s1;
	logic [EW-1:0] fwd_data_s1;

	esput_pkg::sum_upd_t upd_s2;

	logic          accept;
	logic [CW-1:0] idx_ext;
	logic [AW-1:0] idx_addr;
	logic          idx_in_range;
	logic [XW-1:0] amt_ext;
	logic [EW-1:0] rdata;
	logic [EW-1:0] old_entry;
	logic [EW-1:0] new_entry;
	logic [XW-1:0] old_ext;
	logic [XW-1:0] new_ext;
	logic          item_we;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [SW-1:0] sum_raw;

	assign busy   = clr_active_q;
	assign accept = start && !busy;

	// Address and range check of the incoming item.
	assign idx_ext      = CW'(index);
	assign idx_addr     = idx_ext[AW-1:0];
	assign idx_in_range = (32'(index) < 32'(TABLE_DEPTH));
	assign amt_ext      = {{(XW-esput_pkg::AMOUNT_W){amount[esput_pkg::AMOUNT_W-1]}}, amount};

	// Old entry comes from memory unless the previous item just wrote it.
	assign old_entry = fwd_s1 ? fwd_data_s1 : rdata;
	assign new_entry = (act_s1 == esput_pkg::ACT_ADD) ? (old_entry + amt_s1) : amt_s1;
	assign old_ext   = {{(XW-EW){old_entry[EW-1]}}, old_entry};
	assign new_ext   = {{(XW-EW){new_entry[EW-1]}}, new_entry};
	assign item_we   = vld_s1 && rng_s1;

	// The sweep owns the write port after reset; items cannot run meanwhile.
	assign mem_we    = clr_active_q || item_we;
	assign mem_waddr = clr_active_q ? clr_cnt_q : addr_s1;
	assign mem_wdata = clr_active_q ? '0 : new_entry;

	esput_store #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (idx_addr),
		.rdata  (rdata)
	);

	// Clearing sweep over every entry after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == AW'(TABLE_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// Entry stage control, with forwarding of a write to the same entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			fwd_s1 <= accept && item_we && (addr_s1 == idx_addr);
		end
	end

	// Entry stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action;
			rng_s1  <= idx_in_range;
			addr_s1 <= idx_addr;
			amt_s1  <= amt_ext[EW-1:0];
		end
		fwd_data_s1 <= new_entry;
	end

	// Even parts of the old and new entry for the sum stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s2 <= '0;
		end else begin
			upd_s2.valid    <= vld_s1;
			upd_s2.apply    <= rng_s1;
			upd_s2.old_part <= old_entry[0] ? '0 : old_ext[SW-1:0];
			upd_s2.new_part <= new_entry[0] ? '0 : new_ext[SW-1:0];
		end
	end

	esput_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd_s2),
		.done     (done),
		.even_sum (sum_raw)
	);

	assign even_sum = sum_raw;

	`ESP_ASSERT(a_done_latency, clk, arst_n, !done || $past(accept, 3))
	`ESP_ASSERT(a_no_item_in_sweep, clk, arst_n, !(clr_active_q && vld_s1))
	`ESP_ASSERT_NEXT(a_fwd_source, clk, arst_n, accept && item_we && (addr_s1 == idx_addr), fwd_s1 && vld_s1)

endmodule
